// ===== hdl/camera_pose_integrator_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the camera pose integrator checker
// ---------------------------------------------------------------------------
`ifndef CAMERA_POSE_INTEGRATOR_TOP_MACROS_SVH
`define CAMERA_POSE_INTEGRATOR_TOP_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define CPI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpi checker: property failed");

// Next-cycle implication, masked while reset is high.
`define CPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cpi checker: property failed");

// Next-cycle implication that also holds across reset.
`define CPI_ASSERT_NEXT_RAW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cpi checker: property failed");

`endif

// ===== hdl/cpi_pkg.sv =====
// ---------------------------------------------------------------------------
// cpi_pkg
// Shared types, constants and table builders for the camera pose integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package cpi_pkg;

  localparam int TRIG_TABLE_BITS = 10;
  localparam int POS_FRAC_BITS   = 16;
  localparam int TRIG_N          = 1 << TRIG_TABLE_BITS;
  localparam int TRIG_AW         = TRIG_TABLE_BITS + 1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  localparam logic signed [16:0] PITCH_MAX    = 17'sd16384;
  localparam logic signed [16:0] PITCH_MIN    = -17'sd16384;
  localparam logic [15:0]        QUARTER_TURN = 16'h4000;
  localparam logic signed [63:0] RND_HALF     = 64'sd16384;
  localparam logic signed [63:0] Q15_ONE      = 64'sd32768;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_PITCH   = 3'd0,
    CMD_ROLL    = 3'd1,
    CMD_YAW     = 3'd2,
    CMD_FORWARD = 3'd3,
    CMD_STRAFE  = 3'd4,
    CMD_RESET   = 3'd5
  } cmd_code_t;

  typedef enum logic [2:0] {
    OP_PITCH,
    OP_ROLL,
    OP_YAW,
    OP_FWD_LEVEL,
    OP_FWD_FREE,
    OP_STRAFE,
    OP_RESET,
    OP_NOP
  } op_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } back_state_t;

  typedef enum logic [2:0] {
    DST_C,
    DST_X_ADD,
    DST_Y_ADD,
    DST_Y_SUB,
    DST_Z_ADD
  } dest_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] angle_step;
    logic signed [31:0] distance;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] pitch_out;
    logic [15:0]        roll_out;
    logic [15:0]        yaw_out;
  } pose_t;

  typedef struct packed {
    op_code_t           op;
    logic signed [15:0] angle_step;
    logic signed [31:0] distance;
  } op_t;

  typedef struct packed {
    logic  use_pitch;
    logic  is_cos;
    logic  use_c;
    dest_t dest;
  } step_t;

  typedef logic [15:0] qwave_t [TRIG_N + 1];

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Quarter-wave sine magnitudes, Q1.15, by a fixed-point Taylor series.
  function automatic qwave_t build_qwave();
    qwave_t             tbl;
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] r;
    for (int i = 0; i <= TRIG_N; i++) begin
      x    = (64'(i) * HALF_PI_Q30) >> TRIG_TABLE_BITS;
      term = x;
      s    = signed'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'(TAYLOR_DIV[k-1]);
        if ((k & 1) != 0) begin
          s = s - signed'(term);
        end else begin
          s = s + signed'(term);
        end
      end
      if (s < 0) begin
        s = '0;
      end
      r = (s + RND_HALF) >>> 15;
      if (r > Q15_ONE) begin
        r = Q15_ONE;
      end
      tbl[i] = r[15:0];
    end
    return tbl;
  endfunction

  // Multiply steps of each move command, in issue order.
  function automatic step_t step_of(input op_code_t op, input logic [1:0] idx);
    step_t st;
    st = '{use_pitch: 1'b0, is_cos: 1'b0, use_c: 1'b0, dest: DST_X_ADD};
    unique case (op)
      OP_FWD_LEVEL: begin
        st.is_cos = idx[0];
        st.dest   = idx[0] ? DST_Y_SUB : DST_X_ADD;
      end
      OP_STRAFE: begin
        st.is_cos = !idx[0];
        st.dest   = idx[0] ? DST_Y_ADD : DST_X_ADD;
      end
      OP_FWD_FREE: begin
        unique case (idx)
          2'd0: st = '{use_pitch: 1'b1, is_cos: 1'b1, use_c: 1'b0, dest: DST_C};
          2'd1: st = '{use_pitch: 1'b1, is_cos: 1'b0, use_c: 1'b0, dest: DST_Z_ADD};
          2'd2: st = '{use_pitch: 1'b0, is_cos: 1'b0, use_c: 1'b1, dest: DST_X_ADD};
          default: st = '{use_pitch: 1'b0, is_cos: 1'b1, use_c: 1'b1, dest: DST_Y_SUB};
        endcase
      end
      default: begin
      end
    endcase
    return st;
  endfunction

  localparam logic signed [31:0] RESET_X = '0;
  localparam logic signed [31:0] RESET_Y = sat32(-(64'sd200 <<< POS_FRAC_BITS));
  localparam logic signed [31:0] RESET_Z = sat32(64'sd5 <<< POS_FRAC_BITS);

endpackage

`default_nettype wire

// ===== hdl/camera_pose_integrator_top.sv =====
// The back end takes one command at a time: it pops the next from the queue only after the
// last one's pose is loaded into the result register. The steps of a move share the back
// end's single sine table port and its one shared multiplier.
// Reset (rst, synchronous): pose to (0, -200, 5) with zero angles, walking mode, queue empty.
// ---------------------------------------------------------------------------
// camera_pose_integrator_top
// First-person camera pose keeper: front classifies commands, a two-entry
// queue decouples it from the back end, which updates the pose.
// ---------------------------------------------------------------------------
`default_nettype none

module camera_pose_integrator_top (
  input  logic           clk,
  input  logic           rst,
  // command channel
  input  logic           command_valid,
  output logic           command_ready,
  input  cpi_pkg::cmd_t  command,
  // pose result channel
  output logic           pose_valid,
  input  logic           pose_ready,
  output cpi_pkg::pose_t pose,
  // mode register write: cfg_data high selects free flight
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import cpi_pkg::*;

  // Classified command between front, queue and back.
  logic push_valid;
  logic push_ready;
  op_t  push_data;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_data;

  // Front: hold the mode bit, turn each command into an operation code.
  // Forward is split here into level and free flight, so a mode write
  // only affects commands transferred after it.
  cpi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .command_valid (command_valid),
    .command_ready (command_ready),
    .command       (command),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Queue: absorb commands while the back end works or its result waits.
  cpi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: apply rotations at once; for moves, step through sine table
  // lookups and multiplies, then saturate into the position. Drop the pose
  // into the result register when it is free.
  cpi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_data     (pop_data),
    .q_pop      (pop_ready),
    .pose_valid (pose_valid),
    .pose_ready (pose_ready),
    .pose       (pose)
  );

endmodule

`default_nettype wire

// ===== hdl/cpi_front.sv =====
// ---------------------------------------------------------------------------
// cpi_front
// Command intake: holds the mode register and classifies each command.
// ---------------------------------------------------------------------------
`default_nettype none

module cpi_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           command_valid,
  output logic           command_ready,
  input  cpi_pkg::cmd_t  command,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data,
  output logic           push_valid,
  input  logic           push_ready,
  output cpi_pkg::op_t   push_data
);
  import cpi_pkg::*;

  logic     free_flight;
  op_code_t op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_flight <= 1'b0;
    end else if (cfg_valid) begin
      free_flight <= cfg_data;
    end
  end

  // Fold the mode into the forward command so the back end needs no mode.
  always_comb begin
    unique case (command.cmd)
      CMD_PITCH:   op = OP_PITCH;
      CMD_ROLL:    op = OP_ROLL;
      CMD_YAW:     op = OP_YAW;
      CMD_FORWARD: op = free_flight ? OP_FWD_FREE : OP_FWD_LEVEL;
      CMD_STRAFE:  op = OP_STRAFE;
      CMD_RESET:   op = OP_RESET;
      default:     op = OP_NOP;
    endcase
  end

  assign command_ready = push_ready;
  assign push_valid    = command_valid;
  assign push_data     = '{op: op, angle_step: command.angle_step,
                           distance: command.distance};

endmodule

`default_nettype wire

// ===== hdl/cpi_queue.sv =====
// ---------------------------------------------------------------------------
// cpi_queue
// Short FIFO of classified commands between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module cpi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cpi_pkg::op_t  push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cpi_pkg::op_t  pop_data
);
  import cpi_pkg::*;

  op_t               mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpi_back.sv =====
// ---------------------------------------------------------------------------
// cpi_back
// Pose state, sine table, shared multiplier and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cpi_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cpi_pkg::op_t   q_data,
  output logic           q_pop,
  output logic           pose_valid,
  input  logic           pose_ready,
  output cpi_pkg::pose_t pose
);
  import cpi_pkg::*;

  localparam qwave_t QWAVE = build_qwave();

  back_state_t state;
  back_state_t state_next;

  logic signed [15:0] pitch;
  logic [15:0]        roll;
  logic [15:0]        yaw;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  op_code_t           op_code;
  logic signed [31:0] travel;
  logic [1:0]         step_idx;
  logic [1:0]         last_idx;
  logic signed [32:0] c_val;

  logic                      issue;
  logic                      load_out;
  step_t                     cur_step;
  logic [15:0]               look_angle;
  logic [TRIG_TABLE_BITS-1:0] look_idx;
  logic [TRIG_AW-1:0]        look_addr;

  logic               s1_valid;
  step_t              s1_step;
  logic               s1_neg;
  logic [15:0]        rom_q;
  logic               s2_valid;
  dest_t              s2_dest;
  logic signed [49:0] prod;

  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [49:0] rsum;
  logic signed [34:0] rnd;
  logic signed [35:0] addend;
  logic signed [31:0] wb_base;
  logic signed [35:0] wb_sum;
  logic signed [31:0] wb_sat;
  logic signed [16:0] pitch_sum;
  logic signed [15:0] pitch_clamped;

  function automatic logic is_move(input op_code_t op);
    return (op == OP_FWD_LEVEL) || (op == OP_FWD_FREE) || (op == OP_STRAFE);
  endfunction

  assign last_idx = (op_code == OP_FWD_FREE) ? 2'd3 : 2'd1;

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = is_move(q_data.op) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (step_idx == last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid && !s2_valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!pose_valid || pose_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   q_pop    = q_valid;
      ST_RUN:    issue    = 1'b1;
      ST_DRAIN:  begin
      end
      ST_FINISH: load_out = !pose_valid || pose_ready;
      default:   begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---- table address: quadrant folds the quarter wave ----
  assign cur_step   = step_of(op_code, step_idx);
  assign look_angle = (cur_step.use_pitch ? pitch : yaw) +
                      (cur_step.is_cos ? QUARTER_TURN : 16'h0000);
  assign look_idx   = look_angle[13 -: TRIG_TABLE_BITS];
  assign look_addr  = look_angle[14] ? (TRIG_AW'(TRIG_N) - {1'b0, look_idx})
                                     : {1'b0, look_idx};

  always_ff @(posedge clk) begin
    rom_q <= QWAVE[look_addr];
  end

  // ---- multiply and round ----
  assign mul_a  = s1_step.use_c ? c_val : {travel[31], travel};
  assign mul_b  = s1_neg ? -signed'({1'b0, rom_q}) : signed'({1'b0, rom_q});
  assign mul_p  = mul_a * mul_b;
  assign rsum   = prod + 50'sd16384;
  assign rnd    = rsum[49:15];
  assign addend = (s2_dest == DST_Y_SUB) ? -{rnd[34], rnd} : {rnd[34], rnd};

  always_comb begin
    case (s2_dest)
      DST_X_ADD: wb_base = pos_x;
      DST_Z_ADD: wb_base = pos_z;
      default:   wb_base = pos_y;
    endcase
  end

  assign wb_sum = {{4{wb_base[31]}}, wb_base} + addend;
  assign wb_sat = (wb_sum[35:31] == 5'b00000 || wb_sum[35:31] == 5'b11111)
                  ? wb_sum[31:0]
                  : (wb_sum[35] ? 32'sh80000000 : 32'sh7fffffff);

  assign pitch_sum     = {pitch[15], pitch} + {q_data.angle_step[15], q_data.angle_step};
  assign pitch_clamped = (pitch_sum > PITCH_MAX) ? PITCH_MAX[15:0] :
                         (pitch_sum < PITCH_MIN) ? PITCH_MIN[15:0] : pitch_sum[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_step <= cur_step;
    s1_neg  <= look_angle[15];
    s2_dest <= s1_step.dest;
    prod    <= mul_p;
    if (issue) begin
      step_idx <= step_idx + 1'b1;
    end
    if (q_pop) begin
      op_code  <= q_data.op;
      travel   <= q_data.distance;
      step_idx <= '0;
    end
    if (s2_valid && s2_dest == DST_C) begin
      c_val <= rnd[32:0];
    end
  end

  // ---- pose ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch <= '0;
      roll  <= '0;
      yaw   <= '0;
      pos_x <= RESET_X;
      pos_y <= RESET_Y;
      pos_z <= RESET_Z;
    end else begin
      if (q_pop) begin
        case (q_data.op)
          OP_PITCH: pitch <= pitch_clamped;
          OP_ROLL:  roll  <= roll + q_data.angle_step;
          OP_YAW:   yaw   <= yaw + q_data.angle_step;
          OP_RESET: begin
            pitch <= '0;
            roll  <= '0;
            yaw   <= '0;
            pos_x <= RESET_X;
            pos_y <= RESET_Y;
            pos_z <= RESET_Z;
          end
          default: begin
          end
        endcase
      end
      if (s2_valid) begin
        case (s2_dest)
          DST_X_ADD:             pos_x <= wb_sat;
          DST_Y_ADD, DST_Y_SUB:  pos_y <= wb_sat;
          DST_Z_ADD:             pos_z <= wb_sat;
          default: begin
          end
        endcase
      end
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_valid <= 1'b0;
    end else if (load_out) begin
      pose_valid <= 1'b1;
    end else if (pose_ready) begin
      pose_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pose <= '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                pitch_out: pitch, roll_out: roll, yaw_out: yaw};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cpi_checker.sv =====
// ---------------------------------------------------------------------------
// cpi_checker
// Port-level checks on the camera pose integrator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "camera_pose_integrator_top_macros.svh"

module cpi_checker (
  input logic           clk,
  input logic           rst,
  input logic           command_valid,
  input logic           command_ready,
  input cpi_pkg::pose_t pose,
  input logic           pose_valid,
  input logic           pose_ready,
  input logic           cfg_ready
);
  import cpi_pkg::*;

  // Commands accepted but whose pose has not yet been transferred.
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(command_valid && command_ready)
                         - 3'(pose_valid && pose_ready);
    end
  end

  `CPI_ASSERT_NEXT_RAW(a_reset_empties_output, rst, !pose_valid)
  `CPI_ASSERT_SAME(a_no_invented_result, pose_valid, pending != 3'd0 && cfg_ready)
  `CPI_ASSERT_SAME(a_pending_bounded, 1'b1, pending <= 3'd4)
  `CPI_ASSERT_SAME(a_pitch_in_range, pose_valid,
                   pose.pitch_out <= 16'sd16384 && pose.pitch_out >= -16'sd16384)
  `CPI_ASSERT_NEXT(a_result_holds, pose_valid && !pose_ready,
                   pose_valid && $stable(pose))

endmodule

bind camera_pose_integrator_top cpi_checker u_cpi_checker (.*);

`default_nettype wire
